@@ hw/rtl/rhc_pkg.sv @@
// rhc_pkg: shared constants, item types and fixed-point helpers for the RGB/HSL converter.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

  localparam int unsigned COMP_BITS   = 12;
  localparam int unsigned QUO_BITS    = COMP_BITS;
  localparam int unsigned DEN_W       = COMP_BITS + 3;
  localparam int unsigned NUM_W       = 2 * COMP_BITS + 3;
  localparam int unsigned PROD_W      = 2 * COMP_BITS;
  localparam int unsigned NSUM_W      = COMP_BITS + 4;
  localparam int unsigned POS_W       = COMP_BITS + 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COMP_BITS-1:0] comp_t;

  localparam comp_t CMAX = '1;

  localparam logic ACT_TO_HSL = 1'b0;
  localparam logic ACT_TO_RGB = 1'b1;

  typedef enum logic [1:0] {
    MAX_R,
    MAX_G,
    MAX_B
  } max_sel_e;

  typedef struct packed {
    logic  action;
    comp_t in_first;
    comp_t in_second;
    comp_t in_third;
  } in_item_t;

  typedef struct packed {
    comp_t out_first;
    comp_t out_second;
    comp_t out_third;
  } out_item_t;

  // Classified item: rgb extremes or hsl knee term, plus the flat flag
  // (grey input for rgb, zero saturation for hsl).
  typedef struct packed {
    logic               action;
    logic               flat;
    max_sel_e           max_sel;
    comp_t              a;
    comp_t              b;
    comp_t              c;
    comp_t              d;
    logic [COMP_BITS:0] sum;
    comp_t              k;
  } cls_t;

  // Divide by CMAX = 2^COMP_BITS - 1 with a shift-add estimate and one correction.
  function automatic comp_t div_by_max(input logic [PROD_W-1:0] x);
    logic [PROD_W:0]    y;
    logic [COMP_BITS:0] q;
    logic [PROD_W:0]    qm;
    logic [PROD_W:0]    r;
    y  = {1'b0, x} + (PROD_W + 1)'(x >> COMP_BITS);
    q  = y[PROD_W:COMP_BITS];
    qm = {q, {COMP_BITS{1'b0}}} - (PROD_W + 1)'(q);
    r  = {1'b0, x} - qm;
    if (r >= (PROD_W + 1)'(CMAX)) begin
      q = q + 1'b1;
    end
    return q[COMP_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rhc_front.sv @@
// rhc_front: registered classification stage (extremes, hue sector, hsl knee term).
// Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rhc_pkg::in_item_t in_data_i,
  output logic                  cls_valid_o,
  input  wire logic             cls_ready_i,
  output rhc_pkg::cls_t         cls_o
);

  logic          valid_q;
  rhc_pkg::cls_t cls_q, cls_d;

  always_comb begin
    rhc_pkg::comp_t mx, mn;
    rhc_pkg::max_sel_e sel;
    mx  = in_data_i.in_first;
    mn  = in_data_i.in_first;
    sel = rhc_pkg::MAX_R;
    // strict compares keep the first maximum in r, g, b order
    if (in_data_i.in_second > mx) begin
      mx  = in_data_i.in_second;
      sel = rhc_pkg::MAX_G;
    end
    if (in_data_i.in_third > mx) begin
      mx  = in_data_i.in_third;
      sel = rhc_pkg::MAX_B;
    end
    if (in_data_i.in_second < mn) mn = in_data_i.in_second;
    if (in_data_i.in_third < mn) mn = in_data_i.in_third;

    cls_d.action  = in_data_i.action;
    cls_d.max_sel = sel;
    cls_d.a       = in_data_i.in_first;
    cls_d.b       = in_data_i.in_second;
    cls_d.c       = in_data_i.in_third;
    cls_d.d       = mx - mn;
    cls_d.sum     = {1'b0, mx} + {1'b0, mn};
    if ({in_data_i.in_third, 1'b0} < (rhc_pkg::COMP_BITS + 1)'(rhc_pkg::CMAX)) begin
      cls_d.k = in_data_i.in_third;
    end else begin
      cls_d.k = rhc_pkg::CMAX - in_data_i.in_third;
    end
    if (in_data_i.action == rhc_pkg::ACT_TO_RGB) begin
      cls_d.flat = (in_data_i.in_second == '0);
    end else begin
      cls_d.flat = (mx == mn);
    end
  end

  assign in_ready_o  = !valid_q || cls_ready_i;
  assign cls_valid_o = valid_q;
  assign cls_o       = cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cls_q <= cls_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rhc_fifo.sv @@
// rhc_fifo: short flop queue between the classify stage and the arithmetic pipeline.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire rhc_pkg::cls_t push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output rhc_pkg::cls_t      pop_data_o
);

  rhc_pkg::cls_t                mem_q [rhc_pkg::QUEUE_DEPTH];
  logic [rhc_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [rhc_pkg::QCNT_W-1:0]   cnt_q;
  logic                         push, pop;

  assign push_ready_o = (cnt_q != rhc_pkg::QCNT_W'(rhc_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  function automatic logic [rhc_pkg::QPTR_W-1:0] bump(input logic [rhc_pkg::QPTR_W-1:0] p);
    if (p == rhc_pkg::QPTR_W'(rhc_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= bump(wr_ptr_q);
      if (pop) rd_ptr_q <= bump(rd_ptr_q);
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on push");

  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

@@ hw/rtl/rhc_div.sv @@
// rhc_div: pipelined restoring divider, one quotient bit per stage.
// Depends on rhc_pkg; the quotient is known to fit QUO_BITS bits.
`timescale 1ns / 1ps
`default_nettype none

module rhc_div (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [rhc_pkg::NUM_W-1:0] num_i,
  input  wire logic [rhc_pkg::DEN_W-1:0] den_i,
  output logic [rhc_pkg::QUO_BITS-1:0]   quo_o
);

  logic [rhc_pkg::NUM_W-1:0]    rem_q [rhc_pkg::QUO_BITS];
  logic [rhc_pkg::DEN_W-1:0]    den_q [rhc_pkg::QUO_BITS];
  logic [rhc_pkg::QUO_BITS-1:0] quo_q [rhc_pkg::QUO_BITS];

  for (genvar k = 0; k < rhc_pkg::QUO_BITS; k++) begin : g_stage
    logic [rhc_pkg::NUM_W-1:0]    rem_in, trial;
    logic [rhc_pkg::DEN_W-1:0]    den_in;
    logic [rhc_pkg::QUO_BITS-1:0] quo_in;
    logic                         take;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // trial subtrahend: divisor aligned to this stage's quotient bit
    assign trial = rhc_pkg::NUM_W'(den_in) << (rhc_pkg::QUO_BITS - 1 - k);
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? rem_in - trial : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= quo_in |
          (take ? (rhc_pkg::QUO_BITS'(1) << (rhc_pkg::QUO_BITS - 1 - k)) : '0);
      end
    end
  end

  assign quo_o = quo_q[rhc_pkg::QUO_BITS-1];

endmodule

`default_nettype wire

@@ hw/rtl/rhc_back.sv @@
// rhc_back: arithmetic pipeline (two dividers for rgb->hsl, multiply lanes for hsl->rgb)
// and the output register. Depends on rhc_pkg and rhc_div.
`timescale 1ns / 1ps
`default_nettype none

module rhc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rhc_pkg::cls_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rhc_pkg::out_item_t out_data_o
);

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_e;

  typedef struct packed {
    seg_e           seg;
    rhc_pkg::comp_t f;
  } chan_pos_t;

  typedef struct packed {
    logic                        action;
    logic                        flat;
    rhc_pkg::comp_t              lum;
    rhc_pkg::comp_t              h;
    rhc_pkg::comp_t              l;
    logic [rhc_pkg::PROD_W-1:0]  prod;
    logic [rhc_pkg::NUM_W-1:0]   sat_num;
    logic [rhc_pkg::DEN_W-1:0]   sat_den;
    logic [rhc_pkg::NUM_W-1:0]   hue_num;
    logic [rhc_pkg::DEN_W-1:0]   hue_den;
  } p1_t;

  typedef struct packed {
    logic           action;
    logic           flat;
    rhc_pkg::comp_t lum;
  } meta_t;

  typedef struct packed {
    logic                 flat;
    rhc_pkg::comp_t       l;
    rhc_pkg::comp_t       v1;
    rhc_pkg::comp_t       v2;
    chan_pos_t [2:0]      pos;
  } p2_t;

  typedef struct packed {
    logic                             flat;
    rhc_pkg::comp_t                   l;
    rhc_pkg::comp_t                   v1;
    rhc_pkg::comp_t                   v2;
    seg_e [2:0]                       seg;
    logic [2:0][rhc_pkg::PROD_W-1:0]  prod;
  } p3_t;

  // hd_q[0] lines up with meta_q[2]; the last entry must line up with meta_q[QUO_BITS-1]
  localparam int unsigned HD_DEPTH = rhc_pkg::QUO_BITS - 2;

  logic                 en;
  logic                 p1_vld_q;
  p1_t                  p1_q, p1_d;
  logic                 vld_q  [rhc_pkg::QUO_BITS];
  meta_t                meta_q [rhc_pkg::QUO_BITS];
  p2_t                  p2_q, p2_d;
  p3_t                  p3_q, p3_d;
  rhc_pkg::out_item_t   p4_d;
  rhc_pkg::out_item_t   hd_q [HD_DEPTH];
  logic [rhc_pkg::QUO_BITS-1:0] sat_quo, hue_quo;
  logic                 out_valid_q;
  rhc_pkg::out_item_t   out_q, out_d;

  // whole pipeline moves together; it stalls only when the output is held
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  function automatic chan_pos_t place(input logic signed [rhc_pkg::POS_W-1:0] p_in);
    logic signed [rhc_pkg::POS_W-1:0] p, m1, m3, m4, m6, fall;
    chan_pos_t r;
    m1 = $signed(rhc_pkg::POS_W'(rhc_pkg::CMAX));
    m3 = m1 + (m1 <<< 1);
    m4 = m1 <<< 2;
    m6 = m4 + (m1 <<< 1);
    p  = p_in;
    if (p < 0) p = p + m6;
    if (p > m6) p = p - m6;
    fall = m4 - p;
    if (p < m1) begin
      r.seg = SEG_RISE;
      r.f   = p[rhc_pkg::COMP_BITS-1:0];
    end else if (p < m3) begin
      r.seg = SEG_HIGH;
      r.f   = '0;
    end else if (p < m4) begin
      r.seg = SEG_FALL;
      r.f   = fall[rhc_pkg::COMP_BITS-1:0];
    end else begin
      r.seg = SEG_LOW;
      r.f   = '0;
    end
    return r;
  endfunction

  // ---- stage 1: divider operands and the hsl knee product
  always_comb begin
    logic signed [rhc_pkg::NSUM_W-1:0] dd, d6, av, bv, cv, nv;
    logic [rhc_pkg::NSUM_W-2:0]        nu;
    dd = $signed(rhc_pkg::NSUM_W'(in_data_i.d));
    av = $signed(rhc_pkg::NSUM_W'(in_data_i.a));
    bv = $signed(rhc_pkg::NSUM_W'(in_data_i.b));
    cv = $signed(rhc_pkg::NSUM_W'(in_data_i.c));
    d6 = (dd <<< 2) + (dd <<< 1);
    unique case (in_data_i.max_sel)
      rhc_pkg::MAX_R: nv = bv - cv;
      rhc_pkg::MAX_G: nv = (dd <<< 1) + cv - av;
      rhc_pkg::MAX_B: nv = (dd <<< 2) + av - bv;
      default:        nv = '0;
    endcase
    if (nv < 0) nv = nv + d6;
    nu = nv[rhc_pkg::NSUM_W-2:0];

    p1_d.action  = in_data_i.action;
    p1_d.flat    = in_data_i.flat;
    p1_d.lum     = in_data_i.sum[rhc_pkg::COMP_BITS:1];
    p1_d.h       = in_data_i.a;
    p1_d.l       = in_data_i.c;
    p1_d.prod    = rhc_pkg::PROD_W'(in_data_i.b) * rhc_pkg::PROD_W'(in_data_i.k);
    p1_d.sat_num = rhc_pkg::NUM_W'({in_data_i.d, {rhc_pkg::COMP_BITS{1'b0}}})
                 - rhc_pkg::NUM_W'(in_data_i.d);
    if (in_data_i.sum < (rhc_pkg::COMP_BITS + 1)'(rhc_pkg::CMAX)) begin
      p1_d.sat_den = rhc_pkg::DEN_W'(in_data_i.sum);
    end else begin
      p1_d.sat_den = rhc_pkg::DEN_W'({rhc_pkg::CMAX, 1'b0})
                   - rhc_pkg::DEN_W'(in_data_i.sum);
    end
    p1_d.hue_num = {nu, {rhc_pkg::COMP_BITS{1'b0}}} - rhc_pkg::NUM_W'(nu);
    p1_d.hue_den = rhc_pkg::DEN_W'(d6);
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      p1_q <= p1_d;
    end
  end

  rhc_div u_sat_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (p1_q.sat_num),
    .den_i (p1_q.sat_den),
    .quo_o (sat_quo)
  );

  rhc_div u_hue_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (p1_q.hue_num),
    .den_i (p1_q.hue_den),
    .quo_o (hue_quo)
  );

  // ---- hsl stage 2: v1/v2 and hue positions of the three channels
  always_comb begin
    logic [rhc_pkg::COMP_BITS:0]          v2e;
    logic signed [rhc_pkg::COMP_BITS+2:0] v1s;
    logic signed [rhc_pkg::POS_W-1:0]     hx, h6, m2;
    v2e = {1'b0, p1_q.l} + (rhc_pkg::COMP_BITS + 1)'(rhc_pkg::div_by_max(p1_q.prod));
    if (v2e > (rhc_pkg::COMP_BITS + 1)'(rhc_pkg::CMAX)) begin
      p2_d.v2 = rhc_pkg::CMAX;
    end else begin
      p2_d.v2 = v2e[rhc_pkg::COMP_BITS-1:0];
    end
    v1s = $signed({2'b00, p1_q.l, 1'b0}) - $signed((rhc_pkg::COMP_BITS + 3)'(p2_d.v2));
    if (v1s < 0) begin
      p2_d.v1 = '0;
    end else begin
      p2_d.v1 = v1s[rhc_pkg::COMP_BITS-1:0];
    end
    hx = $signed(rhc_pkg::POS_W'(p1_q.h));
    h6 = (hx <<< 2) + (hx <<< 1);
    m2 = $signed(rhc_pkg::POS_W'({rhc_pkg::CMAX, 1'b0}));
    p2_d.pos[0] = place(h6 + m2);
    p2_d.pos[1] = place(h6);
    p2_d.pos[2] = place(h6 - m2);
    p2_d.flat   = p1_q.flat;
    p2_d.l      = p1_q.l;
  end

  // ---- hsl stage 3: one multiplier per channel
  always_comb begin
    rhc_pkg::comp_t span;
    span = p2_q.v2 - p2_q.v1;
    p3_d.flat = p2_q.flat;
    p3_d.l    = p2_q.l;
    p3_d.v1   = p2_q.v1;
    p3_d.v2   = p2_q.v2;
    for (int i = 0; i < 3; i++) begin
      p3_d.seg[i]  = p2_q.pos[i].seg;
      p3_d.prod[i] = rhc_pkg::PROD_W'(span) * rhc_pkg::PROD_W'(p2_q.pos[i].f);
    end
  end

  // ---- hsl stage 4: scale and select per channel
  always_comb begin
    rhc_pkg::comp_t ch [3];
    for (int i = 0; i < 3; i++) begin
      case (p3_q.seg[i])
        SEG_RISE, SEG_FALL: ch[i] = p3_q.v1 + rhc_pkg::div_by_max(p3_q.prod[i]);
        SEG_HIGH:           ch[i] = p3_q.v2;
        default:            ch[i] = p3_q.v1;
      endcase
      if (p3_q.flat) ch[i] = p3_q.l;
    end
    p4_d.out_first  = ch[0];
    p4_d.out_second = ch[1];
    p4_d.out_third  = ch[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q      <= p2_d;
      p3_q      <= p3_d;
      hd_q[0]   <= p4_d;
      for (int i = 1; i < HD_DEPTH; i++) begin
        hd_q[i] <= hd_q[i-1];
      end
      meta_q[0] <= '{action: p1_q.action, flat: p1_q.flat, lum: p1_q.lum};
      for (int i = 1; i < rhc_pkg::QUO_BITS; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  // ---- output select
  always_comb begin
    meta_t m;
    m = meta_q[rhc_pkg::QUO_BITS-1];
    if (m.action == rhc_pkg::ACT_TO_RGB) begin
      out_d = hd_q[HD_DEPTH-1];
    end else begin
      out_d.out_third = m.lum;
      if (m.flat) begin
        out_d.out_first  = '0;
        out_d.out_second = '0;
      end else begin
        out_d.out_second = sat_quo;
        if (hue_quo >= rhc_pkg::CMAX) begin
          out_d.out_first = hue_quo - rhc_pkg::CMAX;
        end else begin
          out_d.out_first = hue_quo;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < rhc_pkg::QUO_BITS; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      p1_vld_q    <= in_valid_i;
      vld_q[0]    <= p1_vld_q;
      for (int i = 1; i < rhc_pkg::QUO_BITS; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_valid_q <= vld_q[rhc_pkg::QUO_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[rhc_pkg::QUO_BITS-1]) begin
      out_q <= out_d;
    end
  end

  a_grey_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[rhc_pkg::QUO_BITS-1]
      && meta_q[rhc_pkg::QUO_BITS-1].action == rhc_pkg::ACT_TO_HSL
      && meta_q[rhc_pkg::QUO_BITS-1].flat
    |=> out_q.out_first == '0 && out_q.out_second == '0)
    else $error("grey input produced nonzero hue or saturation");

  a_flat_rgb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && meta_q[2].action == rhc_pkg::ACT_TO_RGB && meta_q[2].flat
    |-> hd_q[0].out_first == hd_q[0].out_third)
    else $error("zero saturation gave unequal channels");

endmodule

`default_nettype wire

@@ hw/rtl/rgb_hsl_converter.sv @@
// rgb_hsl_converter: top level of the RGB <-> HSL color converter.
// Depends on rhc_pkg, rhc_front, rhc_fifo and rhc_back (which uses rhc_div).
//
//   channel | signals                           | transfer when
//   --------+-----------------------------------+------------------------------
//   in      | in_valid_i in_ready_o in_data_i   | in_valid_i && in_ready_o
//   out     | out_valid_o out_ready_i out_data_o| out_valid_o && out_ready_i
//
// Sustains one transfer per clock on each side unless the output is held. Items
// pass the classify register, the queue and the arithmetic pipeline; the 12-stage
// pipelined dividers (one quotient bit per stage) give saturation and hue.
// Reset (rst_ni low, asynchronous) empties every valid flag and the queue.
// An output stall freezes the arithmetic pipeline; the classify stage and the
// two-entry queue keep taking items until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module rgb_hsl_converter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rhc_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rhc_pkg::out_item_t     out_data_o
);

  logic          cls_valid, cls_ready;
  rhc_pkg::cls_t cls;
  logic          q_valid, q_ready;
  rhc_pkg::cls_t q_data;

  // classify: extremes, hue sector, flat flag
  rhc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cls_valid_o (cls_valid),
    .cls_ready_i (cls_ready),
    .cls_o       (cls)
  );

  // decouple front from back so each can hold on its own
  rhc_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cls_valid),
    .push_ready_o (cls_ready),
    .push_data_i  (cls),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  // arithmetic and output register
  rhc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
